@@ rtl/dqrk_pkg.sv @@
`timescale 1ns / 1ps

package dqrk_pkg;

   localparam int LABEL_MAX = 63;
   localparam int KEY_MAX = 62;
   localparam int KEY_LEN_W = 6;
   localparam logic [7:0] DOT_CHAR = 8'h2E;
   localparam logic [7:0] TERM_BYTE = 8'h00;

   typedef struct packed {
      logic [7:0] name_byte;
      logic       start_of_name;
      logic       packet_end;
   } req_type;

   typedef struct packed {
      logic [7:0]           key_byte;
      logic                 run_last;
      logic                 name_ok;
      logic [KEY_LEN_W-1:0] key_length;
   } rsp_type;

   // shift command broadcast along the cell row
   typedef struct packed {
      logic push;
      logic pop;
   } shift_cmd_type;

endpackage

@@ rtl/dns_qname_reverse_key_unit.sv @@
`timescale 1ns / 1ps
// Name bytes: one request a cycle while the output is free; no key until the terminator.
// After the terminator the emit state pops the key into the output register, one byte
// a cycle while that register is free (up to 62 bytes, from the cell row); no request is taken meanwhile.
// Failure result: registered, valid in the cycle after the offending request.
// Synchronous active-high reset clears control state; the cell row, key length and result payload are not cleared.
module dns_qname_reverse_key_unit #(
   parameter int MAX_NAME_BYTES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dqrk_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dqrk_pkg::rsp_type rsp_payload
);
   import dqrk_pkg::*;

   localparam int POS_W = $clog2(MAX_NAME_BYTES + 1);
   localparam int NLP_W = $clog2(MAX_NAME_BYTES + LABEL_MAX + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COLLECT,
      ST_DONE,
      ST_EMIT
   } state_type;

   // control
   state_type            state_ff, state_in;
   logic [POS_W-1:0]     wp_ff, wp_in;        // next write position
   logic [NLP_W-1:0]     nlp_ff, nlp_in;      // next label-length position
   logic [KEY_LEN_W-1:0] remain_ff, remain_in; // key bytes still to pop
   logic [KEY_LEN_W-1:0] klen_ff, klen_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   // cell row
   shift_cmd_type        cmd;
   logic [7:0]           push_byte;
   logic [7:0]           cell_data [MAX_NAME_BYTES];

   logic                 slot_free;
   logic                 accept;
   logic                 active;
   logic [POS_W-1:0]     pos;
   logic [NLP_W-1:0]     nlp;
   logic [POS_W-1:0]     pos_next;
   logic [POS_W-1:0]     qlen;
   logic                 at_label;

   // Output register frees when empty or being taken.
   assign slot_free = !rsp_valid_ff || rsp_ready;
   // Emission owns the output slot and the cell row.
   assign req_ready = (state_ff != ST_EMIT) && slot_free;
   assign accept    = req_valid && req_ready;

   // A start mark restarts the name whatever the phase.
   assign active   = req_payload.start_of_name || (state_ff == ST_COLLECT);
   assign pos      = req_payload.start_of_name ? '0 : wp_ff;
   assign nlp      = req_payload.start_of_name ? '0 : nlp_ff;
   assign at_label = (NLP_W'(pos) == nlp);
   assign pos_next = pos + POS_W'(1);
   assign qlen     = pos - POS_W'(1);

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      nlp_in       = nlp_ff;
      remain_in    = remain_ff;
      klen_in      = klen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      cmd          = '0;
      push_byte    = req_payload.name_byte;

      if (accept && active) begin
         state_in = ST_COLLECT;
         wp_in    = pos;
         nlp_in   = nlp;
         if (32'(pos) >= MAX_NAME_BYTES) begin
            state_in     = ST_DONE;
            rsp_valid_in = 1'b1;
            rsp_in       = '{key_byte: '0, run_last: 1'b1, name_ok: 1'b0, key_length: '0};
         end else if (at_label && req_payload.name_byte == TERM_BYTE) begin
            if (pos == '0) begin
               // root name
               state_in     = ST_DONE;
               rsp_valid_in = 1'b1;
               rsp_in       = '{key_byte: '0, run_last: 1'b1, name_ok: 1'b0,
                                key_length: '0};
            end else begin
               if (32'(qlen) > KEY_MAX) begin
                  remain_in = KEY_LEN_W'(KEY_MAX);
               end else begin
                  remain_in = KEY_LEN_W'(qlen);
               end
               klen_in  = remain_in;
               state_in = (remain_in == '0) ? ST_DONE : ST_EMIT;
            end
         end else if (at_label && 32'(req_payload.name_byte) > LABEL_MAX) begin
            state_in     = ST_DONE;
            rsp_valid_in = 1'b1;
            rsp_in       = '{key_byte: '0, run_last: 1'b1, name_ok: 1'b0, key_length: '0};
         end else begin
            cmd.push = 1'b1;
            if (at_label) begin
               push_byte = DOT_CHAR;
               nlp_in    = NLP_W'(pos) + NLP_W'(req_payload.name_byte) + NLP_W'(1);
            end
            wp_in = pos_next;
            if (32'(pos_next) >= MAX_NAME_BYTES || req_payload.packet_end) begin
               // buffer full or packet ran out
               state_in     = ST_DONE;
               rsp_valid_in = 1'b1;
               rsp_in       = '{key_byte: '0, run_last: 1'b1, name_ok: 1'b0,
                                key_length: '0};
            end
         end
      end else if (state_ff == ST_EMIT && slot_free) begin
         // top of the stack is the last byte written: pops come out reversed
         cmd.pop      = 1'b1;
         rsp_valid_in = 1'b1;
         rsp_in       = '{key_byte: cell_data[0], run_last: (remain_ff == KEY_LEN_W'(1)),
                          name_ok: 1'b1, key_length: klen_ff};
         remain_in    = remain_ff - KEY_LEN_W'(1);
         if (remain_ff == KEY_LEN_W'(1)) begin
            state_in = ST_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         nlp_ff       <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         nlp_ff       <= nlp_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      klen_ff <= klen_in;
      rsp_ff  <= rsp_in;
   end

   // Row of cells: index 0 is the stack top.
   for (genvar i = 0; i < MAX_NAME_BYTES; i++) begin : g_cell
      logic [7:0] prev_byte;
      logic [7:0] next_byte;
      if (i == 0) begin : g_first
         assign prev_byte = push_byte;
      end else begin : g_mid
         assign prev_byte = cell_data[i-1];
      end
      if (i == MAX_NAME_BYTES - 1) begin : g_last
         assign next_byte = '0;
      end else begin : g_inner
         assign next_byte = cell_data[i+1];
      end
      dqrk_cell u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .from_prev (prev_byte),
         .from_next (next_byte),
         .data      (cell_data[i])
      );
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ rtl/dqrk_cell.sv @@
`timescale 1ns / 1ps

// One byte of the name stack: takes the lower neighbour on push, the upper on pop.
module dqrk_cell (
   input  logic                   clock,
   input  dqrk_pkg::shift_cmd_type cmd,
   input  logic [7:0]             from_prev,
   input  logic [7:0]             from_next,
   output logic [7:0]             data
);
   import dqrk_pkg::*;

   logic [7:0] data_ff;
   logic [7:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (cmd.push) begin
         data_in = from_prev;
      end else if (cmd.pop) begin
         data_in = from_next;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

@@ dv/tb_dns_qname_reverse_key_unit.sv @@
`timescale 1ns / 1ps

module tb_dns_qname_reverse_key_unit;
   import dqrk_pkg::*;

   localparam int MAX_NAME_BYTES = 64;

   typedef enum logic [1:0] {PH_IDLE, PH_COLLECT, PH_DONE} name_phase_type;

   // Mirrors the label walk of the block and holds the reversed keys still owed.
   class key_scoreboard;
      rsp_type        key_queue[$];
      logic [7:0]     name_buf [MAX_NAME_BYTES];
      int unsigned    wr_pos;
      int unsigned    next_lbl;
      name_phase_type phase;
      int             errors;

      function void report_mismatch(string what, int got, int want);
         $display("%0t ns: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
         errors++;
      endfunction

      function void queue_failure();
         rsp_type f;
         f = '0;
         f.run_last = 1'b1;
         key_queue.push_back(f);
         phase = PH_DONE;
      endfunction

      function void note_request(req_type r);
         int unsigned qlen;
         int unsigned cnt;
         rsp_type     k;
         if (r.start_of_name) begin
            phase = PH_COLLECT;
            wr_pos = 0;
            next_lbl = 0;
         end
         if (phase != PH_COLLECT)
            return;
         if (wr_pos >= MAX_NAME_BYTES) begin
            queue_failure();
            return;
         end
         if (wr_pos == next_lbl) begin
            if (r.name_byte == TERM_BYTE) begin
               if (wr_pos == 0) begin
                  queue_failure();
                  return;
               end
               // key is the dotted name reversed, leading dot dropped
               qlen = wr_pos - 1;
               cnt = (qlen > KEY_MAX) ? KEY_MAX : qlen;
               for (int unsigned i = 0; i < cnt; i++) begin
                  k.key_byte = name_buf[qlen - i];
                  k.run_last = (i + 1 == cnt);
                  k.name_ok = 1'b1;
                  k.key_length = cnt[KEY_LEN_W-1:0];
                  key_queue.push_back(k);
               end
               phase = PH_DONE;
               return;
            end
            if (r.name_byte > LABEL_MAX) begin
               queue_failure();
               return;
            end
            name_buf[wr_pos] = DOT_CHAR;
            next_lbl = wr_pos + r.name_byte + 1;
         end else begin
            name_buf[wr_pos] = r.name_byte;
         end
         wr_pos++;
         if (wr_pos >= MAX_NAME_BYTES || r.packet_end)
            queue_failure();
      endfunction

      function void check_result(rsp_type r);
         rsp_type want;
         if (key_queue.size() == 0) begin
            report_mismatch("result with nothing owed", int'(r), 0);
            return;
         end
         want = key_queue.pop_front();
         if (r.key_byte != want.key_byte)
            report_mismatch("key_byte", r.key_byte, want.key_byte);
         if (r.run_last != want.run_last)
            report_mismatch("run_last", r.run_last, want.run_last);
         if (r.name_ok != want.name_ok)
            report_mismatch("name_ok", r.name_ok, want.name_ok);
         if (r.key_length != want.key_length)
            report_mismatch("key_length", r.key_length, want.key_length);
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   key_scoreboard sb;
   req_type       name_q[$];   // bytes of the name being built
   bit            steady;      // no idling on either side while set
   int            sent;
   int            rsp_hold;

   dns_qname_reverse_key_unit #(
      .MAX_NAME_BYTES(MAX_NAME_BYTES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // mostly back to back, some short gaps, the odd long one
   function automatic int pick_gap();
      int roll;
      if (steady)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic req_type raw_req(logic [7:0] b, logic sof, logic pend);
      req_type r;
      r.name_byte = b;
      r.start_of_name = sof;
      r.packet_end = pend;
      return r;
   endfunction

   // first byte of a name carries the start mark
   function automatic void push_byte(logic [7:0] b, logic pend);
      name_q.push_back(raw_req(b, name_q.size() == 0, pend));
   endfunction

   function automatic void add_label(int len);
      push_byte(len[7:0], 1'b0);
      for (int i = 0; i < len; i++)
         push_byte(8'($urandom_range(0, 255)), 1'b0);
   endfunction

   // Valid is only lowered when a gap is due, so a back-to-back request keeps
   // a single assignment per edge.
   task automatic send_request(req_type r);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      sent++;
   endtask

   task automatic send_name();
      foreach (name_q[i])
         send_request(name_q[i]);
      name_q.delete();
   endtask

   // sender idles while the owed results come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.key_queue.size() != 0)
         @(posedge clock);
   endtask

   // Result side: random back-pressure, results checked on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_payload);
         if (rsp_hold != 0) begin
            rsp_ready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 99) < 25)
               rsp_hold = pick_gap();
         end
      end
   end

   initial begin
      int kind;
      int nlab;
      int len;
      int total;
      int names;
      int cut;
      sb = new;
      sent = 0;
      names = 0;
      steady = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // ---- directed ----
      // single-character key, top byte value as a character
      push_byte(8'd1, 1'b0); push_byte(8'hFF, 1'b0); push_byte(TERM_BYTE, 1'b0);
      send_name();
      // oversized label lengths, at both ends of the illegal range
      push_byte(8'hFF, 1'b0); send_name();
      push_byte(8'd64, 1'b0); send_name();
      // root name
      push_byte(TERM_BYTE, 1'b0); send_name();
      // stray byte after completion, no start mark: ignored
      send_request(raw_req(8'h41, 1'b0, 1'b0));
      // packet ends inside a label
      push_byte(8'd2, 1'b0); push_byte(8'h61, 1'b1); send_name();
      // terminator on the last packet byte still succeeds
      push_byte(8'd1, 1'b0); push_byte(8'h62, 1'b0); push_byte(TERM_BYTE, 1'b1);
      send_name();
      // zero bytes inside a label are plain characters
      push_byte(8'd2, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
      push_byte(TERM_BYTE, 1'b0);
      send_name();
      // two labels
      push_byte(8'd1, 1'b0); push_byte(8'h78, 1'b0); push_byte(8'd1, 1'b0);
      push_byte(8'h79, 1'b0); push_byte(TERM_BYTE, 1'b0);
      send_name();
      // start mark mid-name abandons the old one
      push_byte(8'd3, 1'b0); push_byte(8'h61, 1'b0); send_name();
      push_byte(8'd1, 1'b0); push_byte(8'h7A, 1'b0); push_byte(TERM_BYTE, 1'b0);
      send_name();

      // hold off until the block has drained
      wait_drained();

      // longest key: one 62-byte label, terminator at the last legal position
      add_label(62); push_byte(TERM_BYTE, 1'b0); send_name();
      // largest label fills the buffer without a terminator
      add_label(LABEL_MAX); send_name();

      // ---- random ----
      while (sent < 200) begin
         names++;
         if ($urandom_range(0, 4) == 0)
            steady = ~steady;
         if (names % 12 == 0)
            wait_drained();
         kind = $urandom_range(0, 99);
         if (kind < 62) begin
            // well-formed, sometimes padded right up to the buffer limit
            total = 0;
            nlab = $urandom_range(1, 4);
            for (int l = 0; l < nlab; l++) begin
               len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8)
                                                  : $urandom_range(9, 30);
               if (total + len + 1 > 63)
                  len = 63 - total - 1;
               if (len < 1)
                  break;
               add_label(len);
               total += len + 1;
            end
            if ($urandom_range(0, 9) == 0 && 63 - total - 1 >= 1)
               add_label(63 - total - 1);
            push_byte(TERM_BYTE, $urandom_range(0, 3) == 0);
         end else if (kind < 70) begin
            // bad length byte, then some trailing bytes that are ignored
            if ($urandom_range(0, 1) != 0)
               add_label($urandom_range(1, 6));
            push_byte(8'($urandom_range(LABEL_MAX + 1, 255)), 1'b0);
            repeat ($urandom_range(0, 3))
               push_byte(8'($urandom_range(0, 255)), 1'b0);
         end else if (kind < 80) begin
            // packet ends before the terminator
            nlab = $urandom_range(1, 3);
            for (int l = 0; l < nlab; l++)
               add_label($urandom_range(1, 8));
            cut = $urandom_range(1, name_q.size());
            while (name_q.size() > cut)
               void'(name_q.pop_back());
            name_q[name_q.size() - 1].packet_end = 1'b1;
         end else if (kind < 85) begin
            push_byte(TERM_BYTE, $urandom_range(0, 1) != 0);
         end else if (kind < 89) begin
            // buffer runs out with no terminator
            while (name_q.size() < MAX_NAME_BYTES)
               add_label($urandom_range(1, 20));
            while (name_q.size() > MAX_NAME_BYTES)
               void'(name_q.pop_back());
         end else if (kind < 94) begin
            // stray bytes without a start mark
            repeat ($urandom_range(1, 3))
               send_request(raw_req(8'($urandom_range(0, 255)), 1'b0,
                                    $urandom_range(0, 1) != 0));
         end else begin
            // partial name, overtaken by the next start mark
            add_label($urandom_range(2, 10));
            cut = $urandom_range(1, name_q.size() - 1);
            while (name_q.size() > cut)
               void'(name_q.pop_back());
         end
         send_name();
      end

      steady = 1'b0;
      wait_drained();
      // room for any stray result beyond the longest key run
      repeat (80) @(posedge clock);
      if (sb.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
